@@ rtl/lav_pkg.sv @@
package lav_pkg;

    // Q16.16 unit and the rounding half step
    localparam int unsigned Q_ONE  = 65536;
    localparam int unsigned Q_HALF = 32768;

    // Register stages through one normalizer: magnitude and pre-shift, squares, sum,
    // 32 square-root digits, divide setup, 17 quotient bits, sign and output.
    localparam int unsigned NORM_LAT = 54;

    // Signed difference vector into a normalizer, and a unit vector out of it
    typedef logic [2:0][32:0] t_vec33;
    typedef logic [2:0][17:0] t_unit;

endpackage

@@ rtl/lav_norm.sv @@
module lav_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  lav_pkg::t_vec33 i_vec,
    output logic           o_valid,
    output lav_pkg::t_unit o_vec
);
    import lav_pkg::*;

    localparam int unsigned SQ_STEPS  = 32;
    localparam int unsigned DIV_STEPS = 17;

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][30:0] mag;
    } t_lane;

    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [31:0]      len;
        logic [2:0][47:0] rem;
        logic [2:0][16:0] quo;
    } t_div;

    // Magnitudes, pre-shift and squares
    logic             r_va, r_vb, r_vc;
    t_lane            r_la, r_lb, r_lc;
    logic [2:0][61:0] r_sq;
    logic [63:0]      r_sum;

    logic [2:0][32:0] a_mag;
    logic [32:0]      a_max;
    t_lane            n_la;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_la.neg[k] = i_vec[k][32];
            a_mag[k]    = i_vec[k][32] ? (33'd0 - i_vec[k]) : i_vec[k];
        end
        a_max = a_mag[0];
        if (a_mag[1] > a_max) a_max = a_mag[1];
        if (a_mag[2] > a_max) a_max = a_mag[2];
        for (int k = 0; k < 3; k++) begin
            if (a_max[32]) begin
                n_la.mag[k] = a_mag[k][32:2];
            end else if (a_max[31]) begin
                n_la.mag[k] = a_mag[k][31:1];
            end else begin
                n_la.mag[k] = a_mag[k][30:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_la <= n_la;
            r_lb <= r_la;
            r_lc <= r_lb;
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= 62'(r_la.mag[k]) * 62'(r_la.mag[k]);
            end
            r_sum <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
        end
    end

    // Square root, one result bit per stage, two radicand bits consumed each time
    logic        r_sv   [0:SQ_STEPS];
    t_lane       r_sl   [0:SQ_STEPS];
    logic [63:0] r_srad [0:SQ_STEPS];
    logic [33:0] r_srem [0:SQ_STEPS];
    logic [31:0] r_sroot[0:SQ_STEPS];

    always_comb begin
        r_sv[0]    = r_vc;
        r_sl[0]    = r_lc;
        r_srad[0]  = r_sum;
        r_srem[0]  = '0;
        r_sroot[0] = '0;
    end

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        logic [35:0] s_cur;
        logic [35:0] s_try;
        assign s_cur = {r_srem[g], r_srad[g][63:62]};
        assign s_try = {2'b00, r_sroot[g], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[g+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[g+1] <= r_sv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sl[g+1]   <= r_sl[g];
                r_srad[g+1] <= {r_srad[g][61:0], 2'b00};
                if (s_cur >= s_try) begin
                    r_srem[g+1]  <= 34'(s_cur - s_try);
                    r_sroot[g+1] <= {r_sroot[g][30:0], 1'b1};
                end else begin
                    r_srem[g+1]  <= s_cur[33:0];
                    r_sroot[g+1] <= {r_sroot[g][30:0], 1'b0};
                end
            end
        end
    end

    // Division setup: scaled magnitude plus half the length for rounding
    logic r_dv [0:DIV_STEPS];
    t_div r_dd [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= r_sv[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dd[0].zero <= (r_sroot[SQ_STEPS] == 32'd0);
            r_dd[0].neg  <= r_sl[SQ_STEPS].neg;
            r_dd[0].len  <= r_sroot[SQ_STEPS];
            r_dd[0].quo  <= '0;
            for (int k = 0; k < 3; k++) begin
                r_dd[0].rem[k] <= {1'b0, r_sl[SQ_STEPS].mag[k], 16'd0}
                                  + 48'(r_sroot[SQ_STEPS][31:1]);
            end
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        localparam int unsigned BIT = DIV_STEPS - 1 - g;
        logic [48:0] s_dsh;
        assign s_dsh = {17'd0, r_dd[g].len} << BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[g+1] <= r_dv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dd[g+1].zero <= r_dd[g].zero;
                r_dd[g+1].neg  <= r_dd[g].neg;
                r_dd[g+1].len  <= r_dd[g].len;
                for (int k = 0; k < 3; k++) begin
                    if ({1'b0, r_dd[g].rem[k]} >= s_dsh) begin
                        r_dd[g+1].rem[k]      <= 48'({1'b0, r_dd[g].rem[k]} - s_dsh);
                        r_dd[g+1].quo[k]      <= r_dd[g].quo[k] | (17'd1 << BIT);
                    end else begin
                        r_dd[g+1].rem[k]      <= r_dd[g].rem[k];
                        r_dd[g+1].quo[k]      <= r_dd[g].quo[k];
                    end
                end
            end
        end
    end

    // Sign and zero-length handling
    logic  r_ov;
    t_unit r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dv[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                if (r_dd[DIV_STEPS].zero) begin
                    r_out[k] <= '0;
                end else if (r_dd[DIV_STEPS].neg[k]) begin
                    r_out[k] <= 18'd0 - {1'b0, r_dd[DIV_STEPS].quo[k]};
                end else begin
                    r_out[k] <= {1'b0, r_dd[DIV_STEPS].quo[k]};
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_vec   = r_out;

endmodule

@@ rtl/look_at_view_matrix.sv @@
// Left-handed look-at view matrix. Each transfer on the slave side carries an eye point and
// a look-at point in signed Q16.16; each transfer on the master side carries the matching
// camera basis (right, up and forward axes, Q16.16 unit vectors in 18 bits) and the
// translation row (-eye.right, -eye.up, -eye.forward), saturated to 32 bits. The world up
// direction is fixed at (0,1,0). A zero-length forward direction gives zero axes; one that
// points straight up or down gives zero right and up axes. The datapath is a fully
// pipelined chain: a new item may be accepted on every clock cycle unless the master side
// stalls, and each result passes through the two normalizers in series, each of which
// runs a 32-stage square root followed by a 17-stage divide. Backpressure on the master
// side stalls the whole chain at once; nothing is lost or repeated.
module look_at_view_matrix (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z
    input  logic [191:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // right_x/y/z, upaxis_x/y/z, forward_x/y/z (18 bits each), then shift_right,
    // shift_up, shift_forward (32 bits each), six zero pad bits
    output logic [263:0] o_m_tdata
);
    import lav_pkg::*;

    localparam int unsigned EYE_DLY = 2 * NORM_LAT;

    // The whole chain moves whenever the output register is free or being emptied.
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // Stage 0: target minus eye
    logic                    r_v0;
    logic [2:0][31:0]        r_eye0;
    t_vec33                  r_d0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_eye0[k] <= i_s_tdata[32*k +: 32];
                r_d0[k]   <= {i_s_tdata[32*(k+3)+31], i_s_tdata[32*(k+3) +: 32]}
                             - {i_s_tdata[32*k+31], i_s_tdata[32*k +: 32]};
            end
        end
    end

    // Forward axis
    logic  w_valid;
    t_unit w_vec;

    lav_norm u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v0),
        .i_vec   (r_d0),
        .o_valid (w_valid),
        .o_vec   (w_vec)
    );

    // Right axis from (w_z, 0, -w_x)
    t_vec33 t_vec;
    logic   u_valid;
    t_unit  u_vec;

    always_comb begin
        t_vec[0] = 33'(signed'(w_vec[2]));
        t_vec[1] = '0;
        t_vec[2] = 33'd0 - 33'(signed'(w_vec[0]));
    end

    lav_norm u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_valid),
        .i_vec   (t_vec),
        .o_valid (u_valid),
        .o_vec   (u_vec)
    );

    // Delay lines so eye and forward axis meet the right axis
    logic [2:0][31:0] r_eye_dly [0:EYE_DLY-1];
    t_unit            r_w_dly   [0:NORM_LAT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_eye_dly[0] <= r_eye0;
            for (int k = 1; k < EYE_DLY; k++) begin
                r_eye_dly[k] <= r_eye_dly[k-1];
            end
            r_w_dly[0] <= w_vec;
            for (int k = 1; k < NORM_LAT; k++) begin
                r_w_dly[k] <= r_w_dly[k-1];
            end
        end
    end

    logic [2:0][31:0] eye_al;
    t_unit            w_al;
    assign eye_al = r_eye_dly[EYE_DLY-1];
    assign w_al   = r_w_dly[NORM_LAT-1];

    // Round a cross-product difference to Q16.16 and clamp to the unit range.
    function automatic logic [17:0] round_clamp(input logic signed [35:0] s);
        logic [35:0] m;
        logic [20:0] r;
        logic [17:0] c;
        m = s[35] ? (36'd0 - s) : s;
        r = 21'((m + 36'(Q_HALF)) >> 16);
        c = (r > 21'(Q_ONE)) ? 18'(Q_ONE) : r[17:0];
        return s[35] ? (18'd0 - c) : c;
    endfunction

    // Negate a dot product, round it to Q16.16 and saturate to 32 bits.
    function automatic logic [31:0] neg_round_sat(input logic signed [51:0] s);
        logic [51:0] m;
        logic [35:0] r;
        m = s[51] ? (52'd0 - s) : s;
        r = 36'((m + 52'(Q_HALF)) >> 16);
        if (s[51]) begin
            return (r > 36'h07FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
        end
        return (r > 36'h080000000) ? 32'h80000000 : (32'd0 - r[31:0]);
    endfunction

    // Stage P1: cross and dot products
    logic                     r_v1;
    logic signed [5:0][34:0]  r_px;
    logic signed [2:0][49:0]  r_pu, r_pw;
    logic [2:0][31:0]         r_eye1;
    t_unit                    r_u1, r_w1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px[0] <= 35'(signed'(w_al[1])) * 35'(signed'(u_vec[2]));
            r_px[1] <= 35'(signed'(w_al[2])) * 35'(signed'(u_vec[1]));
            r_px[2] <= 35'(signed'(w_al[2])) * 35'(signed'(u_vec[0]));
            r_px[3] <= 35'(signed'(w_al[0])) * 35'(signed'(u_vec[2]));
            r_px[4] <= 35'(signed'(w_al[0])) * 35'(signed'(u_vec[1]));
            r_px[5] <= 35'(signed'(w_al[1])) * 35'(signed'(u_vec[0]));
            for (int k = 0; k < 3; k++) begin
                r_pu[k] <= 50'(signed'(eye_al[k])) * 50'(signed'(u_vec[k]));
                r_pw[k] <= 50'(signed'(eye_al[k])) * 50'(signed'(w_al[k]));
            end
            r_eye1 <= eye_al;
            r_u1   <= u_vec;
            r_w1   <= w_al;
        end
    end

    // Stage P2: up axis, right and forward translations. The elements of a packed array
    // read as unsigned, so each product is marked signed again before it is extended.
    logic             r_v2;
    t_unit            r_v2v, r_u2, r_w2;
    logic [2:0][31:0] r_eye2;
    logic [31:0]      r_shu2, r_shw2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v2v[0] <= round_clamp(36'(signed'(r_px[0])) - 36'(signed'(r_px[1])));
            r_v2v[1] <= round_clamp(36'(signed'(r_px[2])) - 36'(signed'(r_px[3])));
            r_v2v[2] <= round_clamp(36'(signed'(r_px[4])) - 36'(signed'(r_px[5])));
            r_shu2   <= neg_round_sat(52'(signed'(r_pu[0])) + 52'(signed'(r_pu[1]))
                                      + 52'(signed'(r_pu[2])));
            r_shw2   <= neg_round_sat(52'(signed'(r_pw[0])) + 52'(signed'(r_pw[1]))
                                      + 52'(signed'(r_pw[2])));
            r_u2     <= r_u1;
            r_w2     <= r_w1;
            r_eye2   <= r_eye1;
        end
    end

    // Stage P3: eye dot up axis products
    logic                    r_v3;
    logic signed [2:0][49:0] r_pv;
    t_unit                   r_v3v, r_u3, r_w3;
    logic [31:0]             r_shu3, r_shw3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_pv[k] <= 50'(signed'(r_eye2[k])) * 50'(signed'(r_v2v[k]));
            end
            r_v3v  <= r_v2v;
            r_u3   <= r_u2;
            r_w3   <= r_w2;
            r_shu3 <= r_shu2;
            r_shw3 <= r_shw2;
        end
    end

    // Stage P4: output register
    logic         r_v4;
    logic [263:0] r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {6'd0, r_shw3,
                      neg_round_sat(52'(signed'(r_pv[0])) + 52'(signed'(r_pv[1]))
                                    + 52'(signed'(r_pv[2]))),
                      r_shu3, r_w3, r_v3v, r_u3};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= u_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = r_out;

endmodule
